FILE: rtl/acfb_pkg.sv
// shared constants, s-box table and gf helpers for the aes cfb-8 engine
// no dependencies
`default_nettype none
package acfb_pkg;

    localparam int IV_BYTES        = 16;
    localparam int ROUND_KEY_DEPTH = 60;
    localparam int RK_ROW_W        = 4;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_IV_HI  = 3'd4;
    localparam logic [2:0] REG_IV_LO  = 3'd5;
    localparam logic [2:0] REG_KSIZE  = 3'd6;
    localparam logic [2:0] REG_OPER   = 3'd7;

    localparam logic [1:0] KSIZE_128 = 2'd0;
    localparam logic [1:0] KSIZE_192 = 2'd1;

    typedef struct packed {
        logic                we;
        logic [RK_ROW_W-1:0] row;
        logic [127:0]        data;
    } t_rk_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/acfb_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module acfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/acfb_kexp.sv
// aes key schedule sequencer, one word per cycle, four-word rows out
// depends on acfb_pkg
`default_nettype none
module acfb_kexp #(
    parameter int ROUND_KEY_DEPTH = acfb_pkg::ROUND_KEY_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [255:0]   i_key,
    input  wire logic [127:0]   i_iv,
    input  wire logic [1:0]     i_key_size,
    input  wire logic           i_custom,
    output logic                o_busy,
    output acfb_pkg::t_rk_wr    o_wr
);
    logic        r_busy;
    logic [5:0]  r_i;
    logic [2:0]  r_pos;
    logic [3:0]  r_nk;
    logic [5:0]  r_last;
    logic [7:0]  r_rcon;
    logic [31:0] r_win [8];
    logic [31:0] r_buf [3];

    logic [31:0] n_word;
    logic [31:0] n_wm;
    logic [31:0] w_back;
    logic [31:0] w_t;
    logic        w_use_rcon;

    function automatic logic [31:0] key_word(input logic [255:0] key, input logic [127:0] iv,
                                             input logic [2:0] j, input logic custom);
        logic [31:0] w;
        logic [4:0]  idx;
        logic [7:0]  b;
        logic [3:0]  m;
        w = '0;
        for (int k = 0; k < 4; k++) begin
            idx = {j, 2'(k)};
            m   = idx[3:0];
            b   = key[255 - 8*idx -: 8];
            if (custom) begin
                b = {b[4:0], b[7:5]} ^ (8'haa + {4'd0, m}) ^ iv[127 - 8*m -: 8];
            end
            w[31 - 8*k -: 8] = b;
        end
        return w;
    endfunction

    always_comb begin
        unique case (r_nk)
            4'd4:    w_back = r_win[3];
            4'd6:    w_back = r_win[5];
            default: w_back = r_win[7];
        endcase
        w_use_rcon = 1'b0;
        w_t = r_win[0];
        if (r_pos == 3'd0) begin
            w_use_rcon = 1'b1;
            w_t = acfb_pkg::sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'd0};
        end else if (r_nk == 4'd8 && r_pos == 3'd4) begin
            w_t = acfb_pkg::sub_word(r_win[0]);
        end
        if ({2'd0, r_i} < {4'd0, r_nk}) begin
            n_word = key_word(i_key, i_iv, r_i[2:0], i_custom);
        end else begin
            n_word = w_back ^ w_t;
        end
        n_wm = (32'(r_i) < 32'(ROUND_KEY_DEPTH)) ? n_word : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_pos  <= '0;
            r_rcon <= 8'h01;
            priority if (i_key_size == acfb_pkg::KSIZE_128) begin
                r_nk <= 4'd4; r_last <= 6'd43;
            end else if (i_key_size == acfb_pkg::KSIZE_192) begin
                r_nk <= 4'd6; r_last <= 6'd51;
            end else begin
                r_nk <= 4'd8; r_last <= 6'd59;
            end
        end else if (r_busy) begin
            r_i <= r_i + 6'd1;
            r_pos <= ({1'b0, r_pos} == r_nk - 4'd1) ? 3'd0 : r_pos + 3'd1;
            if (w_use_rcon && {2'd0, r_i} >= {4'd0, r_nk}) begin
                r_rcon <= acfb_pkg::xtime(r_rcon);
            end
            r_win[0] <= n_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
            if (r_i[1:0] != 2'd3) begin
                r_buf[r_i[1:0]] <= n_wm;
            end
            if (r_i == r_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy       = r_busy;
    assign o_wr.we      = r_busy && (r_i[1:0] == 2'd3);
    assign o_wr.row     = r_i[5:2];
    assign o_wr.data    = {r_buf[0], r_buf[1], r_buf[2], n_wm};
endmodule
`default_nettype wire

FILE: rtl/aes_cfb8_stream_cipher_unit.sv
// top level of the byte-wide aes cfb-8 engine: apb registers, round sequencer, feedback
// depends on acfb_pkg, acfb_ram, acfb_kexp
//
// channel  direction  handshake            payload
// in       sink       i_valid / o_ready    i_in_byte, i_message_start, i_message_end
// out      source     o_valid / i_ready    o_out_byte, o_last_out
// cfg      apb        psel/penable/pready  paddr, pwdata, prdata
//
// a byte passes the rd0, ark, rnd and out steps, one aes round per cycle
// against the round key memory; a message-start byte first runs the key schedule,
// one key word per cycle. reset clears control and feedback; round keys are
// undefined until the first message start. o_ready is low while a byte is in
// work; a result waiting on i_ready holds the next byte in its last step
`default_nettype none
module aes_cfb8_stream_cipher_unit #(
    parameter int ROUND_KEY_DEPTH = acfb_pkg::ROUND_KEY_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_message_start,
    input  wire logic        i_message_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [7:0]  o_out_byte,
    output logic             o_last_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);
    localparam int RK_ROWS = (ROUND_KEY_DEPTH + 3) / 4;
    localparam int RK_AW   = $clog2(RK_ROWS);

    typedef enum logic [2:0] {S_IDLE, S_KEY, S_RD0, S_ARK, S_RND, S_OUT} t_state;

    t_state       r_state;
    logic [63:0]  r_key [4];
    logic [63:0]  r_iv_hi, r_iv_lo;
    logic [1:0]   r_key_size, r_oper;
    logic [127:0] r_fb, r_st;
    logic [3:0]   r_idx, r_round, r_rounds;
    logic [7:0]   r_data;
    logic         r_last, r_rd_oob;

    logic [127:0] n_round;
    logic [127:0] rk_row, ram_rdata;
    logic [3:0]   rd_row;
    logic [7:0]   n_ks, n_res;
    logic         kx_busy, kx_start, in_beat, cfg_wr;
    acfb_pkg::t_rk_wr kx_wr;

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int k = 0; k < 16; k++) begin
            b[k] = acfb_pkg::SBOX[s[127 - 8*k -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c + r] = b[4*((c + r) % 4) + r];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (!fin) begin
                t[4*c]   = a0 ^ al ^ acfb_pkg::xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ acfb_pkg::xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ acfb_pkg::xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ acfb_pkg::xtime(a3 ^ a0);
            end
        end
        for (int k = 0; k < 16; k++) begin
            o[127 - 8*k -: 8] = t[k];
        end
        return o;
    endfunction

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign o_ready  = (r_state == S_IDLE);
    assign in_beat  = i_valid && o_ready;
    assign kx_start = in_beat && i_message_start;

    always_comb begin
        unique case (paddr[5:3])
            acfb_pkg::REG_KEY0:  prdata = r_key[0];
            acfb_pkg::REG_KEY1:  prdata = r_key[1];
            acfb_pkg::REG_KEY2:  prdata = r_key[2];
            acfb_pkg::REG_KEY3:  prdata = r_key[3];
            acfb_pkg::REG_IV_HI: prdata = r_iv_hi;
            acfb_pkg::REG_IV_LO: prdata = r_iv_lo;
            acfb_pkg::REG_KSIZE: prdata = {62'd0, r_key_size};
            default:             prdata = {62'd0, r_oper};
        endcase
    end

    acfb_kexp #(.ROUND_KEY_DEPTH(ROUND_KEY_DEPTH)) u_kexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (kx_start),
        .i_key      ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_iv       ({r_iv_hi, r_iv_lo}),
        .i_key_size (r_key_size),
        .i_custom   (r_oper[1]),
        .o_busy     (kx_busy),
        .o_wr       (kx_wr)
    );

    always_comb begin
        unique case (r_state)
            S_RD0:   rd_row = 4'd0;
            S_ARK:   rd_row = 4'd1;
            default: rd_row = r_round + 4'd1;
        endcase
    end

    acfb_ram #(.WIDTH(128), .DEPTH(RK_ROWS)) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (kx_wr.we && (32'(kx_wr.row) < 32'(RK_ROWS))),
        .i_waddr (RK_AW'(kx_wr.row)),
        .i_wdata (kx_wr.data),
        .i_raddr (RK_AW'(rd_row)),
        .o_rdata (ram_rdata)
    );

    assign rk_row  = r_rd_oob ? 128'd0 : ram_rdata;
    assign n_round = aes_round(r_st, r_round == r_rounds) ^ rk_row;
    assign n_ks    = r_st[127:120] ^ (r_oper[1] ? r_st[127 - 8*r_idx -: 8] : 8'd0);
    assign n_res   = r_data ^ n_ks;

    always_ff @(posedge i_clk) begin
        r_rd_oob <= (32'(rd_row) >= 32'(RK_ROWS));
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            o_valid    <= 1'b0;
            r_fb       <= '0;
            r_idx      <= '0;
            r_rounds   <= 4'd10;
            r_key      <= '{default: '0};
            r_iv_hi    <= '0;
            r_iv_lo    <= '0;
            r_key_size <= '0;
            r_oper     <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[5:3])
                    acfb_pkg::REG_KEY0:  r_key[0]   <= pwdata;
                    acfb_pkg::REG_KEY1:  r_key[1]   <= pwdata;
                    acfb_pkg::REG_KEY2:  r_key[2]   <= pwdata;
                    acfb_pkg::REG_KEY3:  r_key[3]   <= pwdata;
                    acfb_pkg::REG_IV_HI: r_iv_hi    <= pwdata;
                    acfb_pkg::REG_IV_LO: r_iv_lo    <= pwdata;
                    acfb_pkg::REG_KSIZE: r_key_size <= pwdata[1:0];
                    default:             r_oper     <= pwdata[1:0];
                endcase
            end
            if (o_valid && i_ready && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_data <= i_in_byte;
                        r_last <= i_message_end;
                        if (i_message_start) begin
                            r_fb    <= {r_iv_hi, r_iv_lo};
                            r_idx   <= '0;
                            priority if (r_key_size == acfb_pkg::KSIZE_128) begin
                                r_rounds <= 4'd10;
                            end else if (r_key_size == acfb_pkg::KSIZE_192) begin
                                r_rounds <= 4'd12;
                            end else begin
                                r_rounds <= 4'd14;
                            end
                            r_state <= S_KEY;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_KEY: begin
                    if (!kx_busy) begin
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    r_state <= S_ARK;
                end
                S_ARK: begin
                    r_st    <= r_fb ^ rk_row;
                    r_round <= 4'd1;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_st <= n_round;
                    if (r_round == r_rounds) begin
                        r_state <= S_OUT;
                    end else begin
                        r_round <= r_round + 4'd1;
                    end
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid    <= 1'b1;
                        o_out_byte <= n_res;
                        o_last_out <= r_last;
                        r_fb       <= {r_fb[119:0], r_oper[0] ? r_data : n_res};
                        r_idx      <= r_idx + 4'd1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_start_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kx_start |=> (r_state == S_KEY && kx_busy))
        else $error("message start did not launch key schedule");
    a_wr_in_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kx_wr.we |-> (r_state == S_KEY))
        else $error("round key write outside key schedule");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("output beat not from final step");
    a_round_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND) |-> (r_round <= r_rounds))
        else $error("round counter ran past round count");
`endif

endmodule
`default_nettype wire

FILE: tb/aes_cfb8_stream_cipher_unit_tb.sv
// self-checking testbench for the aes cfb-8 byte stream engine
// holds its own aes and cfb-8 predictor; depends on acfb_pkg and aes_cfb8_stream_cipher_unit
`default_nettype none
module aes_cfb8_stream_cipher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KSIZE_256  = 2'd2;
    localparam logic [1:0] KSIZE_ALT  = 2'd3;
    localparam logic [1:0] OP_DECRYPT = 2'b01;
    localparam logic [1:0] OP_CUSTOM  = 2'b10;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_message_start = 1'b0;
    logic        i_message_end = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = 6'd0;
    logic [63:0] pwdata = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    aes_cfb8_stream_cipher_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_in_byte(i_in_byte), .i_message_start(i_message_start),
        .i_message_end(i_message_end),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_byte(o_out_byte), .o_last_out(o_last_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]   sub_tbl [256];
    logic [63:0]  cfg_reg [8];
    logic [31:0]  rk_mem [60];
    int           rk_rounds;
    logic [127:0] feedback;
    logic [3:0]   fb_index;
    t_out_beat    out_expected_q [$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    function automatic logic [7:0] gf_double(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = gf_double(a);
        end
        return p;
    endfunction

    task automatic build_sub_table();
        logic [7:0] inv;
        logic [7:0] b;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (x != 0 && gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            b = inv;
            sub_tbl[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                         ^ {b[3:0], b[7:4]} ^ 8'h63;
        end
    endtask

    function automatic logic [31:0] sub_bytes4(logic [31:0] w);
        return {sub_tbl[w[31:24]], sub_tbl[w[23:16]], sub_tbl[w[15:8]], sub_tbl[w[7:0]]};
    endfunction

    function automatic logic [7:0] iv_at(int i);
        logic [127:0] iv;
        iv = {cfg_reg[acfb_pkg::REG_IV_HI], cfg_reg[acfb_pkg::REG_IV_LO]};
        return iv[127-8*i -: 8];
    endfunction

    task automatic expand_round_keys();
        logic [255:0] key;
        logic [7:0]   kb [32];
        logic [31:0]  w [60];
        logic [31:0]  t;
        logic [7:0]   b;
        logic [7:0]   rcon;
        int nk, total;
        key = {cfg_reg[acfb_pkg::REG_KEY0], cfg_reg[acfb_pkg::REG_KEY1],
               cfg_reg[acfb_pkg::REG_KEY2], cfg_reg[acfb_pkg::REG_KEY3]};
        case (cfg_reg[acfb_pkg::REG_KSIZE][1:0])
            acfb_pkg::KSIZE_128: nk = 4;
            acfb_pkg::KSIZE_192: nk = 6;
            default:             nk = 8;
        endcase
        total = (nk + 7) * 4;
        rcon = 8'h01;
        for (int i = 0; i < nk * 4; i++) begin
            b = key[255-8*i -: 8];
            if (cfg_reg[acfb_pkg::REG_OPER][1])
                b = {b[4:0], b[7:5]} ^ (8'hAA + 8'(i % 16)) ^ iv_at(i % acfb_pkg::IV_BYTES);
            kb[i] = b;
        end
        for (int i = 0; i < nk; i++) w[i] = {kb[4*i], kb[4*i+1], kb[4*i+2], kb[4*i+3]};
        for (int i = nk; i < total; i++) begin
            t = w[i-1];
            if (i % nk == 0) begin
                t = sub_bytes4({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_double(rcon);
            end else if (nk == 8 && i % nk == 4) begin
                t = sub_bytes4(t);
            end
            w[i] = w[i-nk] ^ t;
        end
        for (int i = 0; i < total; i++) rk_mem[i] = w[i];
        rk_rounds = nk + 6;
    endtask

    function automatic logic [127:0] aes_encrypt(logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [31:0] w;
        for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
        for (int r = 0; r <= rk_rounds; r++) begin
            if (r > 0) begin
                for (int i = 0; i < 16; i++) s[i] = sub_tbl[s[i]];
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++) t[4*c+i] = s[4*((c+i)&3)+i];
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    if (r != rk_rounds) begin
                        all = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                        s[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                        s[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                        s[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
                    end else begin
                        s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                w = rk_mem[r*4+c];
                s[4*c] ^= w[31:24]; s[4*c+1] ^= w[23:16];
                s[4*c+2] ^= w[15:8]; s[4*c+3] ^= w[7:0];
            end
        end
        for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
        return blk;
    endfunction

    task automatic predict_byte(logic [7:0] data, logic start, logic last);
        logic [127:0] ks_blk;
        logic [7:0]   ks;
        t_out_beat    beat;
        if (start) begin
            feedback = {cfg_reg[acfb_pkg::REG_IV_HI], cfg_reg[acfb_pkg::REG_IV_LO]};
            fb_index = 4'd0;
            expand_round_keys();
        end
        ks_blk = aes_encrypt(feedback);
        ks = ks_blk[127:120];
        if (cfg_reg[acfb_pkg::REG_OPER][1]) ks ^= ks_blk[127-8*fb_index -: 8];
        beat.data = data ^ ks;
        beat.last = last;
        feedback = {feedback[119:0], cfg_reg[acfb_pkg::REG_OPER][0] ? data : beat.data};
        fb_index = fb_index + 4'd1;
        out_expected_q.push_back(beat);
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // output beat checker
    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (i_rst_n && o_valid && i_ready) begin
            if (out_expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h", o_out_byte));
            end else begin
                exp_beat = out_expected_q.pop_front();
                if (o_out_byte !== exp_beat.data)
                    report_mismatch($sformatf("out_byte %h, want %h", o_out_byte, exp_beat.data));
                if (o_last_out !== exp_beat.last)
                    report_mismatch($sformatf("last_out %b, want %b", o_last_out, exp_beat.last));
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(logic [7:0] data, logic start, logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            repeat ($urandom_range(6, 1)) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_in_byte <= data;
        i_message_start <= start;
        i_message_end <= last;
        predict_byte(data, start, last);
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        if (i_valid) i_valid <= 1'b0;
        while (out_expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_reg[idx] = value;
    endtask

    task automatic cfg_all(logic [255:0] key, logic [127:0] iv, logic [1:0] ksz, logic [1:0] op);
        cfg_write(acfb_pkg::REG_KEY0, key[255:192]);
        cfg_write(acfb_pkg::REG_KEY1, key[191:128]);
        cfg_write(acfb_pkg::REG_KEY2, key[127:64]);
        cfg_write(acfb_pkg::REG_KEY3, key[63:0]);
        cfg_write(acfb_pkg::REG_IV_HI, iv[127:64]);
        cfg_write(acfb_pkg::REG_IV_LO, iv[63:0]);
        cfg_write(acfb_pkg::REG_KSIZE, {62'd0, ksz});
        cfg_write(acfb_pkg::REG_OPER, {62'd0, op});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_message(int len, bit noisy);
        for (int i = 0; i < len; i++)
            send_byte($urandom_range(255), i == 0 || (noisy && $urandom_range(19) == 0),
                      noisy ? $urandom_range(1) : (i == len - 1));
    endtask

    task automatic test_directed();
        cfg_all('0, '0, acfb_pkg::KSIZE_128, 2'b00);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b1);
        wait_drained();
        cfg_all({256{1'b1}}, {128{1'b1}}, KSIZE_256, OP_DECRYPT);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        wait_drained();
        cfg_all({rand64(), rand64(), rand64(), rand64()}, {rand64(), rand64()},
                KSIZE_ALT, OP_CUSTOM);
        // custom keystream over an index wrap
        for (int i = 0; i < 18; i++) send_byte($urandom_range(255), i == 0, i == 17);
        wait_drained();
        cfg_all({rand64(), rand64(), rand64(), rand64()}, {rand64(), rand64()},
                acfb_pkg::KSIZE_192, OP_CUSTOM | OP_DECRYPT);
        send_byte(8'h5a, 1'b1, 1'b0);
        send_byte(8'ha5, 1'b0, 1'b0);
        wait_drained();
        // mid message: direction flips now, key and iv wait for the next start
        cfg_write(acfb_pkg::REG_OPER, {62'd0, OP_CUSTOM});
        cfg_write(acfb_pkg::REG_KEY0, rand64());
        cfg_write(acfb_pkg::REG_IV_LO, rand64());
        send_byte(8'h3c, 1'b0, 1'b1);
        send_byte(8'hc3, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct);
        int sent;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int s = 0; s < 8; s++) begin
            cfg_all({rand64(), rand64(), rand64(), rand64()}, {rand64(), rand64()},
                    s[1:0], s[2] ? 2'(s + 1) : 2'(s));
            sent = 0;
            while (sent < 60) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12, 1);
                send_message(len, $urandom_range(9) == 0);
                sent += len;
            end
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_all({rand64(), rand64(), rand64(), rand64()}, {rand64(), rand64()},
                acfb_pkg::KSIZE_128, 2'b00);
        hold_left = 400;
        send_message(30, 1'b0);
        wait_drained();
    endtask

    initial begin
        build_sub_table();
        for (int i = 0; i < 8; i++) cfg_reg[i] = 64'd0;
        for (int i = 0; i < 60; i++) rk_mem[i] = 32'd0;
        rk_rounds = 10;
        feedback = '0;
        fb_index = 4'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 0);
        test_random_phase(45, 0);
        test_random_phase(0, 45);
        test_random_phase(22, 22);
        test_backpressure();
        if (error_count == 0 && out_expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/acfb_pkg.sv
rtl/acfb_ram.sv
rtl/acfb_kexp.sv
rtl/aes_cfb8_stream_cipher_unit.sv
tb/aes_cfb8_stream_cipher_unit_tb.sv
